### rtl/i2cmts_pkg.sv
// Package for the I2C master transfer sequencer: opcodes, status event codes,
// ACK action and result codes, the result struct and the error flag encoder.
// No dependencies; the top level refers to it by scoped names.
package i2cmts_pkg;

	localparam int BUF_DEPTH = 16;
	localparam int BUF_AW    = 4;

	typedef enum logic [2:0] {
		OP_LOAD   = 3'd0,
		OP_START  = 3'd1,
		OP_STATUS = 3'd2,
		OP_ERROR  = 3'd3,
		OP_TICK   = 3'd4
	} opcode_t;

	// Controller status words, SR2 in bits 23..16 and SR1 in bits 15..0.
	localparam logic [23:0] EV_MODE_SELECT = 24'h030001;
	localparam logic [23:0] EV_TX_SELECTED = 24'h070082;
	localparam logic [23:0] EV_TX_DONE     = 24'h070084;
	localparam logic [23:0] EV_TX_BUSY     = 24'h070080;
	localparam logic [23:0] EV_RX_SELECTED = 24'h030002;
	localparam logic [23:0] EV_RX_BYTE     = 24'h030044;

	localparam logic [1:0] ACK_LEAVE   = 2'd0;
	localparam logic [1:0] ACK_ENABLE  = 2'd1;
	localparam logic [1:0] ACK_DISABLE = 2'd2;

	localparam logic [3:0] RES_OK      = 4'd0;
	localparam logic [3:0] RES_TIMEOUT = 4'd8;

	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

	typedef struct packed {
		logic       data_write_valid;
		logic [7:0] data_write_byte;
		logic [1:0] ack_action;
		logic       start_request;
		logic       stop_request;
		logic       rx_valid;
		logic [3:0] rx_index;
		logic [7:0] rx_byte;
		logic       done_res;
		logic [3:0] result_code;
	} rsp_t;

	// Counts above the buffer depth saturate to the depth.
	function automatic logic [4:0] sat_count(input logic [4:0] c);
		logic [4:0] r;
		r = (c > 5'(BUF_DEPTH)) ? 5'(BUF_DEPTH) : c;
		return r;
	endfunction

	// Result code from the lowest set error flag among bits 0..6.
	function automatic logic [3:0] flag_code(input logic [7:0] flags);
		logic [3:0] r;
		r = RES_OK;
		for (int i = 6; i >= 0; i--) begin
			if (flags[i]) r = 4'(i + 1);
		end
		return r;
	endfunction

endpackage

### rtl/i2cmts_req_if.sv
// Request channel interface of the I2C master transfer sequencer.
// Carries valid, ready and the command fields; no package dependency.
interface i2cmts_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [3:0]  buf_index;
	logic [7:0]  data_byte;
	logic [7:0]  dev_addr;
	logic        write_present;
	logic [4:0]  write_count;
	logic        read_present;
	logic [4:0]  read_count;
	logic [23:0] status_word;

	modport source (output valid, opcode, buf_index, data_byte, dev_addr, write_present,
		write_count, read_present, read_count, status_word, input ready);
	modport sink (input valid, opcode, buf_index, data_byte, dev_addr, write_present,
		write_count, read_present, read_count, status_word, output ready);
endinterface

### rtl/i2cmts_rsp_if.sv
// Response channel interface of the I2C master transfer sequencer.
// Carries valid, ready and the action fields; no package dependency.
interface i2cmts_rsp_if;
	logic       valid;
	logic       ready;
	logic       data_write_valid;
	logic [7:0] data_write_byte;
	logic [1:0] ack_action;
	logic       start_request;
	logic       stop_request;
	logic       rx_valid;
	logic [3:0] rx_index;
	logic [7:0] rx_byte;
	logic       done_res;
	logic [3:0] result_code;

	modport source (output valid, data_write_valid, data_write_byte, ack_action,
		start_request, stop_request, rx_valid, rx_index, rx_byte, done_res, result_code,
		input ready);
	modport sink (input valid, data_write_valid, data_write_byte, ack_action,
		start_request, stop_request, rx_valid, rx_index, rx_byte, done_res, result_code,
		output ready);
endinterface

### rtl/i2c_master_transfer_sequencer_top.sv
// Top level of the I2C master transfer sequencer: command decode, transfer state,
// write buffer and the registered response. Uses i2cmts_pkg, i2cmts_req_if, i2cmts_rsp_if.
//
//   channel    direction  contents
//   req        in         opcode, buffer load, start parameters, status/error words
//   rsp        out        data register write, ACK/START/STOP requests, rx byte, done
//   cfg_we/wd  in         timeout_ticks register write
//
// Every request transfer produces exactly one response transfer, registered at acceptance
// and offered in the cycle after. A new request is taken every cycle while the response
// register is empty or being drained, so a stalled response stalls the request side.
// Reset clears the transfer state and sets timeout_ticks to 1000; buffer contents
// are undefined until loaded.
module i2c_master_transfer_sequencer_top (
	input  logic                      clk,
	input  logic                      arst_n,
	i2cmts_req_if.sink                req,
	i2cmts_rsp_if.source              rsp,
	input  logic                      cfg_we,
	input  logic [15:0]               cfg_wdata
);

	logic [7:0]  wbuf_q [i2cmts_pkg::BUF_DEPTH];
	logic [7:0]  tgt_addr_q, tgt_addr_n;
	logic [4:0]  wr_rem_q, wr_rem_n;
	logic [4:0]  rd_rem_q, rd_rem_n;
	logic [4:0]  pos_q, pos_n;
	logic        rd_pend_q, rd_pend_n;
	logic        active_q, active_n;
	logic [7:0]  err_q, err_n;
	logic [15:0] tick_q, tick_n;
	logic [15:0] timeout_q;

	i2cmts_pkg::rsp_t rsp_q, res;
	logic             rsp_valid_q;
	logic             accept;
	logic [7:0]       buf_rd;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign buf_rd = (pos_q < 5'(i2cmts_pkg::BUF_DEPTH))
		? wbuf_q[pos_q[i2cmts_pkg::BUF_AW-1:0]] : 8'd0;

	always_comb begin
		tgt_addr_n = tgt_addr_q;
		wr_rem_n   = wr_rem_q;
		rd_rem_n   = rd_rem_q;
		pos_n      = pos_q;
		rd_pend_n  = rd_pend_q;
		active_n   = active_q;
		err_n      = err_q;
		tick_n     = tick_q;
		res        = '0;
		case (req.opcode)
			i2cmts_pkg::OP_START: begin
				if (!active_q) begin
					if (req.write_present) begin
						tgt_addr_n = req.dev_addr & 8'hFE;
					end else if (req.read_present) begin
						tgt_addr_n = req.dev_addr | 8'h01;
					end
					wr_rem_n          = i2cmts_pkg::sat_count(req.write_count);
					rd_rem_n          = i2cmts_pkg::sat_count(req.read_count);
					pos_n             = '0;
					rd_pend_n         = req.read_present;
					err_n             = '0;
					tick_n            = '0;
					active_n          = 1'b1;
					res.ack_action    = i2cmts_pkg::ACK_ENABLE;
					res.start_request = 1'b1;
				end
			end
			i2cmts_pkg::OP_STATUS: begin
				if (active_q) begin
					if (req.status_word == i2cmts_pkg::EV_MODE_SELECT) begin
						res.data_write_valid = 1'b1;
						res.data_write_byte  = tgt_addr_q;
					end else if (req.status_word == i2cmts_pkg::EV_TX_SELECTED
							|| req.status_word == i2cmts_pkg::EV_TX_DONE
							|| req.status_word == i2cmts_pkg::EV_TX_BUSY) begin
						if (wr_rem_q != 5'd0) begin
							res.data_write_valid = 1'b1;
							res.data_write_byte  = buf_rd;
							pos_n                = pos_q + 5'd1;
							wr_rem_n             = wr_rem_q - 5'd1;
						end
						// The last write byte is out: turn around to the read phase or stop.
						if (wr_rem_n == 5'd0) begin
							if (rd_pend_q) begin
								tgt_addr_n        = tgt_addr_q | 8'h01;
								res.ack_action    = i2cmts_pkg::ACK_ENABLE;
								res.start_request = 1'b1;
								pos_n             = '0;
							end else begin
								res.stop_request = 1'b1;
								res.done_res     = 1'b1;
								res.result_code  = i2cmts_pkg::flag_code(err_q);
								active_n         = 1'b0;
							end
						end
					end else if (req.status_word == i2cmts_pkg::EV_RX_SELECTED) begin
						if (rd_rem_q == 5'd1) res.ack_action = i2cmts_pkg::ACK_DISABLE;
					end else if (req.status_word == i2cmts_pkg::EV_RX_BYTE) begin
						if (rd_rem_q != 5'd0) begin
							res.rx_valid = 1'b1;
							res.rx_index = pos_q[3:0];
							res.rx_byte  = req.data_byte;
							pos_n        = pos_q + 5'd1;
							rd_rem_n     = rd_rem_q - 5'd1;
						end
						if (rd_rem_n == 5'd1) begin
							res.ack_action   = i2cmts_pkg::ACK_DISABLE;
							res.stop_request = 1'b1;
						end else if (rd_rem_n == 5'd0) begin
							res.stop_request = 1'b1;
							res.done_res     = 1'b1;
							res.result_code  = i2cmts_pkg::flag_code(err_q);
							active_n         = 1'b0;
						end
					end else begin
						res.stop_request = 1'b1;
						res.done_res     = 1'b1;
						res.result_code  = i2cmts_pkg::flag_code(err_q);
						active_n         = 1'b0;
					end
				end
			end
			i2cmts_pkg::OP_ERROR: begin
				if (active_q && req.status_word[15:8] != 8'd0) begin
					err_n            = req.status_word[15:8];
					res.stop_request = 1'b1;
					res.done_res     = 1'b1;
					res.result_code  = i2cmts_pkg::flag_code(req.status_word[15:8]);
					active_n         = 1'b0;
				end
			end
			i2cmts_pkg::OP_TICK: begin
				if (active_q) begin
					if (tick_q != 16'hFFFF) tick_n = tick_q + 16'd1;
					if (tick_n >= timeout_q) begin
						res.done_res    = 1'b1;
						res.result_code = i2cmts_pkg::RES_TIMEOUT;
						active_n        = 1'b0;
					end
				end
			end
			default: begin
				// Buffer loads touch only the buffer; unused opcodes do nothing.
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_addr_q  <= '0;
			wr_rem_q    <= '0;
			rd_rem_q    <= '0;
			pos_q       <= '0;
			rd_pend_q   <= 1'b0;
			active_q    <= 1'b0;
			err_q       <= '0;
			tick_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				tgt_addr_q <= tgt_addr_n;
				wr_rem_q   <= wr_rem_n;
				rd_rem_q   <= rd_rem_n;
				pos_q      <= pos_n;
				rd_pend_q  <= rd_pend_n;
				active_q   <= active_n;
				err_q      <= err_n;
				tick_q     <= tick_n;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= i2cmts_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) rsp_q <= res;
	end

	always_ff @(posedge clk) begin
		if (accept && req.opcode == i2cmts_pkg::OP_LOAD
				&& {1'b0, req.buf_index} < 5'(i2cmts_pkg::BUF_DEPTH)) begin
			wbuf_q[req.buf_index] <= req.data_byte;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.data_write_valid = rsp_q.data_write_valid;
	assign rsp.data_write_byte  = rsp_q.data_write_byte;
	assign rsp.ack_action       = rsp_q.ack_action;
	assign rsp.start_request    = rsp_q.start_request;
	assign rsp.stop_request     = rsp_q.stop_request;
	assign rsp.rx_valid         = rsp_q.rx_valid;
	assign rsp.rx_index         = rsp_q.rx_index;
	assign rsp.rx_byte          = rsp_q.rx_byte;
	assign rsp.done_res         = rsp_q.done_res;
	assign rsp.result_code      = rsp_q.result_code;

endmodule

### rtl/i2cmts_checker.sv
// Port-level checks for the I2C master transfer sequencer top level, and the bind
// that attaches them. Depends on i2c_master_transfer_sequencer_top and its interfaces.
module i2cmts_port_checks (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       rsp_done,
	input logic [3:0] rsp_code,
	input logic       rsp_rx_valid,
	input logic [3:0] rsp_rx_index,
	input logic [7:0] rsp_rx_byte
);

	// A stalled response stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// Every accepted request yields a response in the next cycle.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("accepted request without a response");

	// The result code only means something when a transfer finishes.
	a_code_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_done |-> rsp_code == 4'd0)
		else $error("result code set without done");

	// Index and byte of the received data are zero when nothing is delivered.
	a_rx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_rx_valid |-> rsp_rx_index == 4'd0 && rsp_rx_byte == 8'd0)
		else $error("rx fields set without rx_valid");

endmodule

bind i2c_master_transfer_sequencer_top i2cmts_port_checks u_i2cmts_port_checks (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_done     (rsp.done_res),
	.rsp_code     (rsp.result_code),
	.rsp_rx_valid (rsp.rx_valid),
	.rsp_rx_index (rsp.rx_index),
	.rsp_rx_byte  (rsp.rx_byte)
);
